// ===== sv/tlf_pkg.sv =====
package tlf_pkg;

  // field widths of the request and result channels
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned ORDER_W   = 8;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned PAYLOAD_W = 32;

  // request kinds
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

endpackage

// ===== sv/tlf_ctrl.sv =====
module tlf_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PTR_W       = 4,
  parameter int unsigned OCC_W       = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req,
  input  tlf_pkg::kind_t              kind,
  output logic                        wr_en,
  output logic [PTR_W-1:0]            wr_addr,
  output logic                        rd_en,
  output logic [PTR_W-1:0]            rd_addr,
  output logic [tlf_pkg::TICK_W-1:0]  stamp_tick,
  output logic [tlf_pkg::ORDER_W-1:0] stamp_order,
  output logic                        valid_r,
  output logic                        ok_r,
  output logic                        pop_r,
  output logic                        full_r,
  output logic                        empty_r
);

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(QUEUE_DEPTH);

  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0]            occ_r, occ_nxt;
  logic [tlf_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic [tlf_pkg::ORDER_W-1:0] order_r, order_nxt;
  logic                        ok_nxt, pop_nxt;
  logic                        can_wr, can_rd;

  assign can_wr = (occ_r != FULL_OCC);
  assign can_rd = (occ_r != '0);

  assign wr_addr     = wr_ptr_r;
  assign rd_addr     = rd_ptr_r;
  assign stamp_tick  = tick_r;
  assign stamp_order = order_r;

  // next state for one request
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    tick_nxt   = tick_r;
    order_nxt  = order_r;
    ok_nxt     = 1'b0;
    pop_nxt    = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    if (req) begin
      unique case (kind)
        tlf_pkg::KIND_WRITE: begin
          if (can_wr) begin
            wr_en      = 1'b1;
            ok_nxt     = 1'b1;
            order_nxt  = order_r + 1'b1;
            wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
            occ_nxt    = occ_r + 1'b1;
          end
        end
        tlf_pkg::KIND_READ: begin
          if (can_rd) begin
            rd_en      = 1'b1;
            ok_nxt     = 1'b1;
            pop_nxt    = 1'b1;
            rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
            occ_nxt    = occ_r - 1'b1;
          end
        end
        tlf_pkg::KIND_TICK: begin
          tick_nxt  = tick_r + 1'b1;
          order_nxt = '0;
        end
        tlf_pkg::KIND_CLEAR: begin
          wr_ptr_nxt = '0;
          rd_ptr_nxt = '0;
          occ_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // queue state and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
      tick_r   <= '0;
      order_r  <= '0;
      valid_r  <= 1'b0;
      ok_r     <= 1'b0;
      pop_r    <= 1'b0;
      full_r   <= 1'b0;
      empty_r  <= 1'b1;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
      tick_r   <= tick_nxt;
      order_r  <= order_nxt;
      valid_r  <= req;
      ok_r     <= ok_nxt;
      pop_r    <= pop_nxt;
      full_r   <= (occ_nxt == FULL_OCC);
      empty_r  <= (occ_nxt == '0);
    end
  end

endmodule

// ===== sv/tlf_store.sv =====
module tlf_store #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PTR_W       = 4,
  parameter int unsigned STORE_PW    = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [PTR_W-1:0]              wr_addr,
  input  logic [tlf_pkg::TICK_W-1:0]    wr_tick,
  input  logic [tlf_pkg::ORDER_W-1:0]   wr_order,
  input  logic [tlf_pkg::TYPE_W-1:0]    wr_type,
  input  logic [STORE_PW-1:0]           wr_payload,
  input  logic                          rd_en,
  input  logic [PTR_W-1:0]              rd_addr,
  output logic [tlf_pkg::TICK_W-1:0]    rd_tick_r,
  output logic [tlf_pkg::ORDER_W-1:0]   rd_order_r,
  output logic [tlf_pkg::TYPE_W-1:0]    rd_type_r,
  output logic [STORE_PW-1:0]           rd_payload_r
);

  localparam int unsigned ENTRY_W =
    tlf_pkg::TICK_W + tlf_pkg::ORDER_W + tlf_pkg::TYPE_W + STORE_PW;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

  // entry write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tick, wr_order, wr_type, wr_payload};
    end
  end

  // registered read of the oldest entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_tick_r, rd_order_r, rd_type_r, rd_payload_r} <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/timestamped_log_fifo.sv =====
// the result strobe (out_valid) is registered and rises in the cycle after a request is accepted
// throughput: one request per cycle; busy is never raised
// the result is held on the out_ ports for one cycle only; the receiver cannot stall
// entry reads come from a registered memory port, written and read once per cycle
// reset (rst_n low, synchronous): pointers, occupancy, tick and order counters to zero
// stored entries are not cleared and are only read once written
module timestamped_log_fifo #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PAYLOAD_BYTES = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [tlf_pkg::TYPE_W-1:0]      in_entry_type,
  input  logic [tlf_pkg::PAYLOAD_W-1:0]   in_entry_payload,
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [tlf_pkg::TICK_W-1:0]      out_read_tick,
  output logic [tlf_pkg::ORDER_W-1:0]     out_read_order,
  output logic [tlf_pkg::TYPE_W-1:0]      out_read_type,
  output logic [tlf_pkg::PAYLOAD_W-1:0]   out_read_payload,
  output logic                            out_is_full,
  output logic                            out_is_empty
);

  localparam int unsigned PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STORE_PW = (PAYLOAD_BYTES >= 4) ? tlf_pkg::PAYLOAD_W
                                                          : 8 * PAYLOAD_BYTES;

  logic                        req;
  logic                        wr_en, rd_en;
  logic [PTR_W-1:0]            wr_addr, rd_addr;
  logic [tlf_pkg::TICK_W-1:0]  stamp_tick;
  logic [tlf_pkg::ORDER_W-1:0] stamp_order;
  logic                        pop_r;
  logic [tlf_pkg::TICK_W-1:0]  rd_tick_r;
  logic [tlf_pkg::ORDER_W-1:0] rd_order_r;
  logic [tlf_pkg::TYPE_W-1:0]  rd_type_r;
  logic [STORE_PW-1:0]         rd_payload_r;

  // a request is taken in every cycle
  assign busy = 1'b0;
  assign req  = start & ~busy;

  tlf_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W),
    .OCC_W       (OCC_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .kind        (tlf_pkg::kind_t'(in_kind)),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .stamp_tick  (stamp_tick),
    .stamp_order (stamp_order),
    .valid_r     (out_valid),
    .ok_r        (out_ok),
    .pop_r       (pop_r),
    .full_r      (out_is_full),
    .empty_r     (out_is_empty)
  );

  tlf_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W),
    .STORE_PW    (STORE_PW)
  ) u_store (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_tick      (stamp_tick),
    .wr_order     (stamp_order),
    .wr_type      (in_entry_type),
    .wr_payload   (in_entry_payload[STORE_PW-1:0]),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_tick_r    (rd_tick_r),
    .rd_order_r   (rd_order_r),
    .rd_type_r    (rd_type_r),
    .rd_payload_r (rd_payload_r)
  );

  // popped entry fields, zero when no entry came out
  assign out_read_tick    = pop_r ? rd_tick_r  : '0;
  assign out_read_order   = pop_r ? rd_order_r : '0;
  assign out_read_type    = pop_r ? rd_type_r  : '0;
  assign out_read_payload = pop_r ? tlf_pkg::PAYLOAD_W'(rd_payload_r) : '0;

endmodule

// ===== test/timestamped_log_fifo_test.sv =====
`timescale 1ns / 1ps

module timestamped_log_fifo_test;
  import tlf_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned ENTRY_BYTES   = 4;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // one popped-entry result as seen on the out_ ports
  typedef struct {
    logic                 ok;
    logic [TICK_W-1:0]    tick;
    logic [ORDER_W-1:0]   order;
    logic [TYPE_W-1:0]    etype;
    logic [PAYLOAD_W-1:0] payload;
    logic                 full;
    logic                 empty;
  } log_result_t;

  // shadow of the log queue plus the results still owed by the block
  class log_scoreboard;
    logic [TICK_W-1:0]    slot_tick    [DEPTH];
    logic [ORDER_W-1:0]   slot_order   [DEPTH];
    logic [TYPE_W-1:0]    slot_type    [DEPTH];
    logic [PAYLOAD_W-1:0] slot_payload [DEPTH];
    int unsigned          wr_ptr;
    int unsigned          rd_ptr;
    int unsigned          fill;
    logic [TICK_W-1:0]    tick_now;
    logic [ORDER_W-1:0]   order_now;
    log_result_t          owed_q[$];
    int unsigned          failures;

    function new();
      wr_ptr    = 0;
      rd_ptr    = 0;
      fill      = 0;
      tick_now  = '0;
      order_now = '0;
      failures  = 0;
    endfunction

    // apply one accepted request to the shadow queue and queue its result
    function void note_request(kind_t kind, logic [TYPE_W-1:0] etype,
                               logic [PAYLOAD_W-1:0] payload);
      log_result_t res;
      res = '{default: '0};
      case (kind)
        KIND_WRITE: begin
          if (fill < DEPTH) begin
            slot_tick[wr_ptr]    = tick_now;
            slot_order[wr_ptr]   = order_now;
            slot_type[wr_ptr]    = etype;
            slot_payload[wr_ptr] = payload;
            order_now            = order_now + 1'b1;
            wr_ptr               = (wr_ptr + 1) % DEPTH;
            fill++;
            res.ok = 1'b1;
          end
        end
        KIND_READ: begin
          if (fill > 0) begin
            res.tick    = slot_tick[rd_ptr];
            res.order   = slot_order[rd_ptr];
            res.etype   = slot_type[rd_ptr];
            res.payload = slot_payload[rd_ptr];
            rd_ptr      = (rd_ptr + 1) % DEPTH;
            fill--;
            res.ok = 1'b1;
          end
        end
        KIND_TICK: begin
          tick_now  = tick_now + 1'b1;
          order_now = '0;
        end
        default: begin
          // clear keeps both counters
          wr_ptr = 0;
          rd_ptr = 0;
          fill   = 0;
        end
      endcase
      res.full  = (fill >= DEPTH);
      res.empty = (fill == 0);
      owed_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    // compare one strobed result with the oldest owed one
    function void check_result(log_result_t got);
      log_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result strobe with no request outstanding", $time);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      compare_field("ok", want.ok, got.ok);
      compare_field("read_tick", want.tick, got.tick);
      compare_field("read_order", want.order, got.order);
      compare_field("read_type", want.etype, got.etype);
      compare_field("read_payload", want.payload, got.payload);
      compare_field("is_full", want.full, got.full);
      compare_field("is_empty", want.empty, got.empty);
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_kind;
  logic [TYPE_W-1:0]    in_entry_type;
  logic [PAYLOAD_W-1:0] in_entry_payload;
  logic                 out_valid;
  logic                 out_ok;
  logic [TICK_W-1:0]    out_read_tick;
  logic [ORDER_W-1:0]   out_read_order;
  logic [TYPE_W-1:0]    out_read_type;
  logic [PAYLOAD_W-1:0] out_read_payload;
  logic                 out_is_full;
  logic                 out_is_empty;

  log_scoreboard sb = new();
  int unsigned   stall_count = 0;

  timestamped_log_fifo #(
    .QUEUE_DEPTH   (DEPTH),
    .PAYLOAD_BYTES (ENTRY_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_entry_type    (in_entry_type),
    .in_entry_payload (in_entry_payload),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_read_tick    (out_read_tick),
    .out_read_order   (out_read_order),
    .out_read_type    (out_read_type),
    .out_read_payload (out_read_payload),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // monitor: check results, note accepted requests, watch for a hang
  always @(posedge clk) begin
    log_result_t got;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        got.ok      = out_ok;
        got.tick    = out_read_tick;
        got.order   = out_read_order;
        got.etype   = out_read_type;
        got.payload = out_read_payload;
        got.full    = out_is_full;
        got.empty   = out_is_empty;
        sb.check_result(got);
      end
      if (start && busy === 1'b0)
        sb.note_request(kind_t'(in_kind), in_entry_type, in_entry_payload);
      if (out_valid === 1'b1 || (start && busy === 1'b0))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no activity for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // present one request and hold it until it is taken
  task automatic send_request(kind_t kind, logic [TYPE_W-1:0] etype,
                              logic [PAYLOAD_W-1:0] payload);
    @(negedge clk);
    start            <= 1'b1;
    in_kind          <= kind;
    in_entry_type    <= etype;
    in_entry_payload <= payload;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender idle with junk on the fields
  task automatic idle_for(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start            <= 1'b0;
      in_kind          <= 2'($urandom);
      in_entry_type    <= 8'($urandom);
      in_entry_payload <= $urandom;
    end
  endtask

  // mostly short gaps, now and then a long one
  task automatic random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)
      idle_for(0);
    else if (r < 90)
      idle_for($urandom_range(1, 3));
    else
      idle_for($urandom_range(10, 40));
  endtask

  // hold off until every owed result has come back
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [PAYLOAD_W-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // random requests with the given kind weights
  task automatic run_phase(int unsigned n_items, int unsigned w_write, int unsigned w_read,
                           int unsigned w_tick, int unsigned w_clear, bit with_gaps);
    int unsigned r;
    kind_t       kind;
    repeat (n_items) begin
      r = $urandom_range(0, w_write + w_read + w_tick + w_clear - 1);
      if (r < w_write)
        kind = KIND_WRITE;
      else if (r < w_write + w_read)
        kind = KIND_READ;
      else if (r < w_write + w_read + w_tick)
        kind = KIND_TICK;
      else
        kind = KIND_CLEAR;
      send_request(kind, 8'($urandom), pick_payload());
      if (with_gaps)
        random_gap();
    end
  endtask

  // stimulus
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_kind          = KIND_WRITE;
    in_entry_type    = '0;
    in_entry_payload = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty read, field extremes, ticks, clear
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'hff, 32'hffff_ffff);
    send_request(KIND_WRITE, 8'ha5, 32'h5a5a_5a5a);
    send_request(KIND_READ, 8'hff, 32'hffff_ffff);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'h01, 32'h0000_0001);
    send_request(KIND_TICK, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'h02, 32'h0000_0002);
    send_request(KIND_TICK, 8'hff, 32'hffff_ffff);
    send_request(KIND_TICK, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'h80, 32'h8000_0000);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'h7f, 32'h7fff_ffff);
    send_request(KIND_WRITE, 8'h5a, 32'ha5a5_a5a5);
    send_request(KIND_CLEAR, 8'hff, 32'hffff_ffff);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    send_request(KIND_WRITE, 8'h03, 32'h0000_0003);
    send_request(KIND_READ, 8'h00, 32'h0000_0000);
    wait_for_drain();

    // fill up and push against a full queue
    run_phase(200, 75, 15, 5, 5, 1'b0);
    wait_for_drain();
    // drain against an empty queue
    run_phase(150, 25, 70, 5, 0, 1'b1);
    wait_for_drain();
    // long stretch within one tick so the order number wraps
    run_phase(600, 50, 50, 0, 0, 1'b0);
    wait_for_drain();
    // everything mixed
    run_phase(250, 40, 35, 15, 10, 1'b1);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== timestamped_log_fifo.f =====
sv/tlf_pkg.sv
sv/tlf_ctrl.sv
sv/tlf_store.sv
sv/timestamped_log_fifo.sv
test/timestamped_log_fifo_test.sv
